@@ src/rycc_pkg.sv @@
// Shared types, constants, the size clamp and the weighted-sum function of the RGB to YCbCr converter.
`default_nettype none
package rycc_pkg;

   // Frame size limits and the widths that follow from them.
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int CFG_W      = 13;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int MAX_SIZE   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SIZE_W     = $clog2(MAX_SIZE + 1);
   localparam int CMP_W      = ((CFG_W > SIZE_W) ? CFG_W : SIZE_W) + 1;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd360;

   // BT.601 studio-swing coefficients.
   localparam logic signed [8:0] Y_KR  = 9'sd66;
   localparam logic signed [8:0] Y_KG  = 9'sd129;
   localparam logic signed [8:0] Y_KB  = 9'sd25;
   localparam logic signed [8:0] CB_KR = -9'sd38;
   localparam logic signed [8:0] CB_KG = -9'sd74;
   localparam logic signed [8:0] CB_KB = 9'sd112;
   localparam logic signed [8:0] CR_KR = 9'sd112;
   localparam logic signed [8:0] CR_KG = -9'sd94;
   localparam logic signed [8:0] CR_KB = -9'sd18;
   localparam logic signed [17:0] ROUND_BIAS = 18'sd128;
   localparam int SHIFT = 8;
   localparam logic [7:0] Y_OFFSET = 8'd16;
   localparam logic [7:0] C_OFFSET = 8'd128;

   typedef enum logic [1:0] {
      CHROMA_NONE = 2'd0,
      CHROMA_CB   = 2'd1,
      CHROMA_CR   = 2'd2
   } chroma_kind_type;

   // Classified pixel passed from the front to the back.
   typedef struct packed {
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
      chroma_kind_type kind;
      logic            frame_end;
   } pixel_type;

   typedef struct packed {
      logic [7:0]      luma;
      logic [7:0]      chroma;
      chroma_kind_type kind;
      logic            frame_end;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
   } queue_status_type;

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   // Clamp a configured size into 2..maxv.
   function automatic logic [CMP_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int maxv);
      logic [CMP_W-1:0] ext;
      logic [CMP_W-1:0] lim;
      ext = CMP_W'(v);
      lim = CMP_W'(maxv);
      if (ext < CMP_W'(2)) begin
         return CMP_W'(2);
      end else if (ext > lim) begin
         return lim;
      end
      return ext;
   endfunction

   // ((kr R + kg G + kb B + 128) >>> 8) + offset, kept to 8 bits.
   function automatic logic [7:0] weigh(input logic signed [8:0] kr,
                                        input logic signed [8:0] kg,
                                        input logic signed [8:0] kb,
                                        input logic [7:0] r,
                                        input logic [7:0] g,
                                        input logic [7:0] b,
                                        input logic [7:0] offset);
      logic signed [17:0] pr;
      logic signed [17:0] pg;
      logic signed [17:0] pb;
      logic signed [17:0] sum;
      logic signed [17:0] shifted;
      pr      = 18'(kr) * 18'($signed({1'b0, r}));
      pg      = 18'(kg) * 18'($signed({1'b0, g}));
      pb      = 18'(kb) * 18'($signed({1'b0, b}));
      sum     = pr + pg + pb + ROUND_BIAS;
      shifted = sum >>> SHIFT;
      return shifted[7:0] + offset;
   endfunction

endpackage
`default_nettype wire

@@ src/rgb_to_ycbcr_420_converter_core.sv @@
// Top level of the RGB to YCbCr 4:2:0 converter.
//
// Pixels enter in raster order on the req_ queue port: a beat is taken at a
// clock edge with push high and full low. Every pixel yields one result beat
// on the rsp_ queue port: luma, a Cb sample at even columns of even rows or a
// Cr sample at even columns of odd rows (chroma_kind tells which), and
// frame_end on the last pixel of the frame. A result is taken at an edge with
// pop high and empty low.
// A pushed pixel waits in the pixel queue, then passes through the arithmetic
// into the result queue, which drives the rsp_ ports.
// Throughput: one pixel per cycle while the receiver pops every result; one
// pass through the weighted sums per pixel sets it.
// When the receiver stalls, the two-entry result queue and then the two-entry
// pixel queue fill; full rises once four pixels are held in the block.
// Frame size is written through the csr_ port, index 0 width, index 1 height;
// csr_ready is always high. Write it only while the block is idle.
// Reset clears both queues and the position counters and loads a 640 x 360
// frame size.
`default_nettype none
module rgb_to_ycbcr_420_converter_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rycc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rycc_pkg::CFG_W-1:0]      csr_wdata,
   input  wire logic                            push,
   output logic                                 full,
   input  wire logic [7:0]                      req_red,
   input  wire logic [7:0]                      req_green,
   input  wire logic [7:0]                      req_blue,
   output logic                                 empty,
   input  wire logic                            pop,
   output logic [7:0]                           rsp_luma,
   output logic [7:0]                           rsp_chroma,
   output logic [1:0]                           rsp_chroma_kind,
   output logic                                 rsp_frame_end
);

   rycc_pkg::pixel_type        pixel;
   logic                       pixel_valid;
   logic                       pixel_take;
   rycc_pkg::result_type       result;
   rycc_pkg::queue_status_type front_status;
   rycc_pkg::queue_status_type back_status;

   rycc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .push        (push),
      .full        (full),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .pixel       (pixel),
      .pixel_valid (pixel_valid),
      .pixel_take  (pixel_take),
      .status      (front_status)
   );

   rycc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pixel       (pixel),
      .pixel_valid (pixel_valid),
      .pixel_take  (pixel_take),
      .result      (result),
      .empty       (empty),
      .pop         (pop),
      .status      (back_status)
   );

   assign rsp_luma        = result.luma;
   assign rsp_chroma      = result.chroma;
   assign rsp_chroma_kind = result.kind;
   assign rsp_frame_end   = result.frame_end;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      front_status.count <= rycc_pkg::QUEUE_DEPTH && back_status.count <= rycc_pkg::QUEUE_DEPTH)
      else $error("queue count beyond depth");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> (front_status.count != 2'd0))
      else $error("accepted pixel missing from pixel queue");

   a_no_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_chroma_kind == rycc_pkg::CHROMA_NONE) |-> (rsp_chroma == 8'd0))
      else $error("chroma nonzero on a pixel without chroma");

   a_take_has_room: assert property (@(posedge clock) disable iff (reset)
      pixel_take |-> (pixel_valid && back_status.count != rycc_pkg::QUEUE_DEPTH))
      else $error("pixel moved with no room in result queue");

endmodule
`default_nettype wire

@@ src/rycc_front.sv @@
// Front end: size registers, position counters, chroma classification and the pixel queue.
`default_nettype none
module rycc_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rycc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rycc_pkg::CFG_W-1:0]          csr_wdata,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [7:0]                          req_red,
   input  wire logic [7:0]                          req_green,
   input  wire logic [7:0]                          req_blue,
   output rycc_pkg::pixel_type                      pixel,
   output logic                                     pixel_valid,
   input  wire logic                                pixel_take,
   output rycc_pkg::queue_status_type               status
);

   logic [rycc_pkg::CFG_W-1:0] width_ff, width_in;
   logic [rycc_pkg::CFG_W-1:0] height_ff, height_in;
   logic [rycc_pkg::COL_W-1:0] col_ff, col_in;
   logic [rycc_pkg::ROW_W-1:0] row_ff, row_in;
   rycc_pkg::pixel_type        entry_ff [2];
   logic                       wr_ptr_ff, wr_ptr_in;
   logic                       rd_ptr_ff, rd_ptr_in;
   logic [1:0]                 count_ff, count_in;

   logic                       accept;
   logic                       take;
   logic                       last_col;
   logic                       last_row;
   logic [rycc_pkg::CMP_W-1:0] w_lim;
   logic [rycc_pkg::CMP_W-1:0] h_lim;
   logic [rycc_pkg::CMP_W-1:0] col_next;
   logic [rycc_pkg::CMP_W-1:0] row_next;
   rycc_pkg::pixel_type        beat;

   assign csr_ready   = 1'b1;
   assign full        = (count_ff == rycc_pkg::QUEUE_DEPTH);
   assign accept      = push && !full;
   assign pixel_valid = (count_ff != 2'd0);
   assign take        = pixel_take && pixel_valid;
   assign pixel       = entry_ff[rd_ptr_ff];
   assign status      = '{count: count_ff};

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rycc_pkg::CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            rycc_pkg::CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Position tracking: a counter whose next value is at or past its limit ends the row or frame.
   always_comb begin
      w_lim    = rycc_pkg::clamp_size(width_ff, rycc_pkg::MAX_WIDTH);
      h_lim    = rycc_pkg::clamp_size(height_ff, rycc_pkg::MAX_HEIGHT);
      col_next = rycc_pkg::CMP_W'(col_ff) + rycc_pkg::CMP_W'(1);
      row_next = rycc_pkg::CMP_W'(row_ff) + rycc_pkg::CMP_W'(1);
      last_col = (col_next >= w_lim);
      last_row = (row_next >= h_lim);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[rycc_pkg::ROW_W-1:0];
         end else begin
            col_in = col_next[rycc_pkg::COL_W-1:0];
         end
      end
   end

   always_comb begin
      beat.red       = req_red;
      beat.green     = req_green;
      beat.blue      = req_blue;
      beat.frame_end = last_col && last_row;
      if (col_ff[0]) begin
         beat.kind = rycc_pkg::CHROMA_NONE;
      end else if (row_ff[0]) begin
         beat.kind = rycc_pkg::CHROMA_CR;
      end else begin
         beat.kind = rycc_pkg::CHROMA_CB;
      end
   end

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(accept) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rycc_pkg::FRAME_WIDTH_RESET;
         height_ff <= rycc_pkg::FRAME_HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= beat;
      end
   end

endmodule
`default_nettype wire

@@ src/rycc_back.sv @@
// Back end: luma and chroma arithmetic and the result queue.
`default_nettype none
module rycc_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rycc_pkg::pixel_type    pixel,
   input  wire logic                   pixel_valid,
   output logic                        pixel_take,
   output rycc_pkg::result_type        result,
   output logic                        empty,
   input  wire logic                   pop,
   output rycc_pkg::queue_status_type  status
);

   rycc_pkg::result_type entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 deliver;
   rycc_pkg::result_type beat;

   assign empty      = (count_ff == 2'd0);
   assign deliver    = pop && !empty;
   assign pixel_take = pixel_valid && (count_ff != rycc_pkg::QUEUE_DEPTH);
   assign result     = entry_ff[rd_ptr_ff];
   assign status     = '{count: count_ff};

   always_comb begin
      beat.luma      = rycc_pkg::weigh(rycc_pkg::Y_KR, rycc_pkg::Y_KG, rycc_pkg::Y_KB,
                                       pixel.red, pixel.green, pixel.blue,
                                       rycc_pkg::Y_OFFSET);
      beat.kind      = pixel.kind;
      beat.frame_end = pixel.frame_end;
      unique case (pixel.kind)
         rycc_pkg::CHROMA_CB: beat.chroma = rycc_pkg::weigh(rycc_pkg::CB_KR, rycc_pkg::CB_KG,
                                            rycc_pkg::CB_KB, pixel.red, pixel.green,
                                            pixel.blue, rycc_pkg::C_OFFSET);
         rycc_pkg::CHROMA_CR: beat.chroma = rycc_pkg::weigh(rycc_pkg::CR_KR, rycc_pkg::CR_KG,
                                            rycc_pkg::CR_KB, pixel.red, pixel.green,
                                            pixel.blue, rycc_pkg::C_OFFSET);
         default:             beat.chroma = 8'd0;
      endcase
   end

   always_comb begin
      wr_ptr_in = pixel_take ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deliver ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(pixel_take) - 2'(deliver);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_take) begin
         entry_ff[wr_ptr_ff] <= beat;
      end
   end

endmodule
`default_nettype wire
